// File: hw/rtl/mpts_pkg.sv
// Package for the multi-policy task scheduler: payload structs, codes, constants.
// No dependencies.
package mpts_pkg;

  typedef struct packed {
    logic        op;
    logic [7:0]  task_id;
    logic [15:0] burst_len;
    logic [7:0]  prio_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  running_id;
    logic        finished;
    logic [7:0]  finished_id;
    logic [23:0] finished_wait;
    logic [23:0] finished_turnaround;
  } out_item_t;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_SRTF = 3'd2;
  localparam logic [2:0] POL_RR   = 3'd3;
  localparam logic [2:0] POL_PRIO = 3'd4;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [7:0]  QUANTUM_RESET = 8'd2;
  localparam logic [23:0] CNT24_MAX     = 24'hFFFFFF;
  localparam logic [15:0] ORDER_MAX     = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_HOLD, S_SCAN, S_UPD, S_RESP
  } state_e;

  typedef struct packed {
    logic clr_best;   // start selection scan
    logic scan;       // compare entry at index
    logic upd;        // apply counter update to entry at index
    logic do_add;     // write new task
    logic finish_tick;// settle tick result after sweep
    logic idx_clr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic hold;       // non-preemptive current task stays
  } sts_t;

endpackage

// File: hw/rtl/mpts_ctrl.sv
// Controller FSM of the task scheduler: sequences add, scan and update sweeps.
// Depends on mpts_pkg.
module mpts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic             in_op_i,
  input  logic             out_busy_i,
  input  mpts_pkg::sts_t   sts_i,
  output mpts_pkg::cmd_t   cmd_o,
  output logic             in_ready_o
);
  import mpts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire_i) state_d = (in_op_i == OP_TICK) ? S_HOLD : S_ADD;
      S_ADD:  state_d = S_RESP;
      S_HOLD: state_d = sts_i.hold ? S_UPD : S_SCAN;
      S_SCAN: if (sts_i.idx_last) state_d = S_UPD;
      S_UPD:  if (sts_i.idx_last) state_d = S_RESP;
      S_RESP: if (!out_busy_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.idx_clr = 1'b1;
        cmd_o.clr_best = 1'b1;
      end
      S_ADD:  cmd_o.do_add = 1'b1;
      S_HOLD: cmd_o.idx_clr = 1'b1;
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.idx_last) cmd_o.idx_clr = 1'b1;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        if (sts_i.idx_last) cmd_o.finish_tick = 1'b1;
      end
      S_RESP: if (!out_busy_i) cmd_o.load_out = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == S_IDLE) else $error("load without return");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.idx_last) |=> state_q == S_UPD)
    else $error("scan did not end in update");
endmodule

// File: hw/rtl/mpts_dp.sv
// Datapath of the task scheduler: task table, selection scan, counter sweep.
// Depends on mpts_pkg.
module mpts_dp #(
  parameter int unsigned TableEntries = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpts_pkg::cmd_t      cmd_i,
  output mpts_pkg::sts_t      sts_o,
  input  logic                in_fire_i,
  input  mpts_pkg::in_item_t  in_item_i,
  input  logic [2:0]          policy_i,
  input  logic [7:0]          quantum_i,
  output mpts_pkg::out_item_t res_o
);
  import mpts_pkg::*;

  localparam int unsigned IW = $clog2(TableEntries);

  logic [TableEntries-1:0] valid_q;
  logic [7:0]  id_q   [TableEntries];
  logic [15:0] rem_q  [TableEntries];
  logic [7:0]  pri_q  [TableEntries];
  logic [15:0] ord_q  [TableEntries];
  logic [23:0] wait_q [TableEntries];
  logic [23:0] turn_q [TableEntries];

  in_item_t    item_q;
  logic [IW-1:0] idx_q;
  logic        cur_v_q;
  logic [IW-1:0] cur_q;
  logic [7:0]  slice_q;
  logic [15:0] arr_q;
  logic        best_v_q;
  logic [IW-1:0] best_q;
  logic [2:0]  k_q;
  out_item_t   res_q;

  logic [2:0]  k;
  logic [7:0]  q;
  assign k = (policy_i <= POL_PRIO) ? policy_i : POL_FCFS;
  assign q = (quantum_i == 8'd0) ? 8'd1 : quantum_i;

  // lowest free slot
  logic          free_v;
  logic [IW-1:0] free_i;
  always_comb begin
    free_v = 1'b0;
    free_i = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_v = 1'b1;
        free_i = IW'(i);
      end
    end
  end

  assign sts_o.idx_last = (idx_q == IW'(TableEntries - 1));
  assign sts_o.hold = cur_v_q && valid_q[cur_q] &&
                      (k == POL_FCFS || k == POL_SJF || k == POL_RR);

  // candidate idx_q beats best_q?
  logic better;
  always_comb begin
    better = ord_q[idx_q] < ord_q[best_q];
    if (k_q == POL_SJF || k_q == POL_SRTF) begin
      if (rem_q[idx_q] != rem_q[best_q]) better = rem_q[idx_q] < rem_q[best_q];
    end else if (k_q == POL_PRIO) begin
      if (pri_q[idx_q] != pri_q[best_q]) better = pri_q[idx_q] > pri_q[best_q];
    end
  end

  logic [15:0] rem_dec;
  assign rem_dec = (rem_q[best_q] != 16'd0) ? rem_q[best_q] - 16'd1 : 16'd0;
  logic        fin;
  assign fin = (rem_dec == 16'd0);
  logic [7:0]  slice_n;
  always_comb begin
    slice_n = (cur_v_q && cur_q == best_q) ? slice_q : 8'd0;
    if (slice_n != 8'hFF) slice_n = slice_n + 8'd1;
  end

  // the sweep has already bumped the chosen entry unless it is the last one
  logic [23:0] turn_inc;
  assign turn_inc = (turn_q[best_q] != CNT24_MAX) ? turn_q[best_q] + 24'd1 : CNT24_MAX;

  out_item_t add_res;
  out_item_t tick_res;
  always_comb begin
    add_res = '0;
    add_res.status = free_v ? ST_OK : ST_FULL;
  end

  always_comb begin
    tick_res = '0;
    if (!best_v_q) begin
      tick_res.status = ST_EMPTY;
    end else begin
      tick_res.running_id = id_q[best_q];
      if (fin) begin
        tick_res.finished            = 1'b1;
        tick_res.finished_id         = id_q[best_q];
        tick_res.finished_wait       = wait_q[best_q];
        tick_res.finished_turnaround = (idx_q == best_q) ? turn_inc : turn_q[best_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      idx_q    <= '0;
      cur_v_q  <= 1'b0;
      cur_q    <= '0;
      slice_q  <= '0;
      arr_q    <= '0;
      best_v_q <= 1'b0;
      best_q   <= '0;
      k_q      <= '0;
      res_q    <= '0;
    end else begin
      if (in_fire_i) begin
        item_q <= in_item_i;
        k_q    <= (k == POL_RR) ? POL_FCFS : k;
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.scan || cmd_i.upd) idx_q <= idx_q + IW'(1);
      if (cmd_i.clr_best) best_v_q <= 1'b0;
      if (sts_o.hold && !cmd_i.scan && !cmd_i.upd && !cmd_i.clr_best && !cmd_i.do_add
          && !cmd_i.finish_tick && !cmd_i.load_out && cmd_i.idx_clr) begin
        best_v_q <= 1'b1;
        best_q   <= cur_q;
      end
      if (cmd_i.scan && valid_q[idx_q] && (!best_v_q || better)) begin
        best_v_q <= 1'b1;
        best_q   <= idx_q;
      end
      if (cmd_i.do_add) begin
        res_q <= add_res;
        if (free_v) begin
          valid_q[free_i] <= 1'b1;
          id_q[free_i]    <= item_q.task_id;
          rem_q[free_i]   <= item_q.burst_len;
          pri_q[free_i]   <= item_q.prio_level;
          ord_q[free_i]   <= arr_q;
          wait_q[free_i]  <= '0;
          turn_q[free_i]  <= '0;
          if (arr_q != ORDER_MAX) arr_q <= arr_q + 16'd1;
        end
      end
      if (cmd_i.upd && best_v_q && valid_q[idx_q]) begin
        if (turn_q[idx_q] != CNT24_MAX) turn_q[idx_q] <= turn_q[idx_q] + 24'd1;
        if (idx_q != best_q && wait_q[idx_q] != CNT24_MAX)
          wait_q[idx_q] <= wait_q[idx_q] + 24'd1;
      end
      if (cmd_i.finish_tick) begin
        res_q <= tick_res;
        if (!best_v_q) begin
          cur_v_q <= 1'b0;
          slice_q <= '0;
        end else begin
          rem_q[best_q] <= rem_dec;
          if (fin) begin
            valid_q[best_q] <= 1'b0;
            cur_v_q <= 1'b0;
            slice_q <= '0;
          end else if (k == POL_RR && slice_n >= q) begin
            ord_q[best_q] <= arr_q;
            if (arr_q != ORDER_MAX) arr_q <= arr_q + 16'd1;
            cur_v_q <= 1'b0;
            slice_q <= '0;
          end else begin
            cur_v_q <= 1'b1;
            cur_q   <= best_q;
            slice_q <= slice_n;
          end
        end
      end
    end
  end

  assign res_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish_tick && best_v_q) |-> valid_q[best_q]) else $error("bad pick");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> valid_q[cur_q]) else $error("current slot not valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> slice_q != 8'd0) else $error("current with zero slice");
endmodule

// File: hw/rtl/multi_policy_task_scheduler_unit.sv
// Top level of the multi-policy task scheduler: config registers, FSM, datapath.
// Depends on mpts_pkg, mpts_ctrl, mpts_dp.
//
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid/in_ready   | in_item_i (op, id, burst, prio)
//  out     | from block| out_valid/out_ready | out_item_o (status, ids, counts)
//  cfg     | to block  | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
//
// An add's result is valid after the table write; a tick's result is valid
// after one selection sweep and one counter sweep over the table, one entry
// per cycle; a held non-preemptive task skips the selection sweep. One item at
// a time: the next item is taken only once the result has been taken. Config
// writes are taken only while the controller is idle and hold off a new item
// in that cycle. Reset empties the table, clears the current task and sets
// policy FCFS, quantum 2.
module multi_policy_task_scheduler_unit #(
  parameter int unsigned TableEntries = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mpts_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpts_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import mpts_pkg::*;

  logic [2:0] policy_q;
  logic [7:0] quantum_q;
  logic       out_v_q;
  out_item_t  out_q;
  cmd_t       cmd;
  sts_t       sts;
  out_item_t  res;
  logic       rdy;
  logic       in_fire;

  // config only between items
  assign cfg_ready_o = rdy;
  // only accept when the output register is free and no config write is offered
  assign in_ready_o  = rdy && !out_v_q && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_FCFS;
      quantum_q <= QUANTUM_RESET;
      out_v_q   <= 1'b0;
      out_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_POLICY) policy_q <= cfg_data_i[2:0];
        else                           quantum_q <= cfg_data_i;
      end
      if (cmd.load_out) begin
        out_v_q <= 1'b1;
        out_q   <= res;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  mpts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (in_fire),
    .in_op_i   (in_item_i.op),
    .out_busy_i(out_v_q),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_ready_o(rdy)
  );

  mpts_dp #(.TableEntries(TableEntries)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_fire_i (in_fire),
    .in_item_i (in_item_i),
    .policy_i  (policy_q),
    .quantum_i (quantum_q),
    .res_o     (res)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !out_v_q) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o) else $error("second item taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status != 2'd3) else $error("bad status");
endmodule
